// ===== design/hrhp_pkg.sv =====
// Shared types, constants and helpers of the HTTP request head parser.
// Depends on nothing; every other design file imports it.
package hrhp_pkg;

	localparam int DATA_W = 8;
	localparam int OFS_W = 12;
	localparam int HDR_W = 6;
	localparam int EV_W = 3;
	localparam int MATCH_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	// Defaults of the top-level parameters.
	localparam int BUF_BYTES_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Headers at or past this ordinal are never recorded, whatever the register says.
	localparam int MAX_HEADERS = 64;

	localparam logic [HDR_W-1:0] HEADER_LIMIT_RESET = HDR_W'(15);

	// Register indexes of the configuration port.
	localparam logic [CFG_ADDR_W-3:0] REG_HEADER_LIMIT = '0;

	// Method word progress: letters matched so far, or a mismatch.
	localparam logic [MATCH_W-1:0] MATCH_NONE = MATCH_W'(0);
	localparam logic [MATCH_W-1:0] MATCH_ONE = MATCH_W'(1);
	localparam logic [MATCH_W-1:0] MATCH_BAD = MATCH_W'(7);
	localparam logic [MATCH_W-1:0] GET_LEN = MATCH_W'(4);
	localparam logic [MATCH_W-1:0] POST_LEN = MATCH_W'(5);

	// Characters of the grammar.
	localparam logic [DATA_W-1:0] CH_SPACE = " ";
	localparam logic [DATA_W-1:0] CH_SLASH = "/";
	localparam logic [DATA_W-1:0] CH_COLON = ":";
	localparam logic [DATA_W-1:0] CH_DOT = ".";
	localparam logic [DATA_W-1:0] CH_DASH = "-";
	localparam logic [DATA_W-1:0] CH_LF = 8'h0A;
	localparam logic [DATA_W-1:0] CH_ONE = "1";
	localparam logic [DATA_W-1:0] CH_G = "G";
	localparam logic [DATA_W-1:0] CH_E = "E";
	localparam logic [DATA_W-1:0] CH_T = "T";
	localparam logic [DATA_W-1:0] CH_P = "P";
	localparam logic [DATA_W-1:0] CH_O = "O";
	localparam logic [DATA_W-1:0] CH_S = "S";
	localparam logic [DATA_W-1:0] CH_UA = "A";
	localparam logic [DATA_W-1:0] CH_UZ = "Z";
	localparam logic [DATA_W-1:0] CH_LA = "a";
	localparam logic [DATA_W-1:0] CH_LZ = "z";

	// Result events.
	typedef enum logic [EV_W-1:0] {
		EV_NONE = 3'd0,
		EV_URI = 3'd1,
		EV_HEADER = 3'd2,
		EV_DONE = 3'd3,
		EV_ERROR = 3'd4
	} ev_t;

	// Parser phases, one-hot.
	typedef enum logic [13:0] {
		PH_START = 14'b00000000000001,
		PH_METHOD = 14'b00000000000010,
		PH_URI = 14'b00000000000100,
		PH_PROTO = 14'b00000000001000,
		PH_MAJOR = 14'b00000000010000,
		PH_MINOR = 14'b00000000100000,
		PH_HSTART = 14'b00000001000000,
		PH_KEY = 14'b00000010000000,
		PH_COLON = 14'b00000100000000,
		PH_SPACE = 14'b00001000000000,
		PH_VALUE = 14'b00010000000000,
		PH_VDONE = 14'b00100000000000,
		PH_DONE = 14'b01000000000000,
		PH_ERROR = 14'b10000000000000
	} phase_t;

	// A received word together with its character class.
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic begin_req;
		logic upper;
		logic lower;
		logic space;
		logic slash;
		logic colon;
		logic dot;
		logic lf;
		logic dash;
		logic one;
	} hrhp_byte_t;

	// Expected letter of the method word at a given place.
	function automatic logic [DATA_W-1:0] method_char(input logic post,
			input logic [MATCH_W-1:0] n);
		logic [DATA_W-1:0] c;
		c = '0;
		case ({post, n})
			{1'b0, 3'd0}: c = CH_G;
			{1'b0, 3'd1}: c = CH_E;
			{1'b0, 3'd2}: c = CH_T;
			{1'b0, 3'd3}: c = CH_SPACE;
			{1'b1, 3'd0}: c = CH_P;
			{1'b1, 3'd1}: c = CH_O;
			{1'b1, 3'd2}: c = CH_S;
			{1'b1, 3'd3}: c = CH_T;
			{1'b1, 3'd4}: c = CH_SPACE;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== design/hrhp_if.sv =====
// Handshake channels of the HTTP request head parser: request words in,
// parse events out. Depends on hrhp_pkg.
interface hrhp_in_if;
	import hrhp_pkg::*;
	logic valid;
	logic ready;
	logic [DATA_W-1:0] data_byte;
	logic begin_request;
	modport source(output valid, input ready, output data_byte, output begin_request);
	modport sink(input valid, output ready, input data_byte, input begin_request);
endinterface

interface hrhp_out_if;
	import hrhp_pkg::*;
	logic valid;
	logic ready;
	logic [EV_W-1:0] event_res;
	logic method_post;
	logic [OFS_W-1:0] span_start;
	logic [OFS_W-1:0] span_len;
	logic [OFS_W-1:0] value_start;
	logic [OFS_W-1:0] value_len;
	logic [HDR_W-1:0] header_index;
	logic header_kept;
	modport source(output valid, input ready, output event_res, output method_post,
		output span_start, output span_len, output value_start, output value_len,
		output header_index, output header_kept);
	modport sink(input valid, output ready, input event_res, input method_post,
		input span_start, input span_len, input value_start, input value_len,
		input header_index, input header_kept);
endinterface

// ===== design/hrhp_front.sv =====
// Front stage: accepts request words and registers them with their character class.
// Depends on hrhp_pkg and hrhp_in_if.
module hrhp_front (
	input logic clk,
	input logic arst_n,
	hrhp_in_if.sink in_ch,
	output hrhp_pkg::hrhp_byte_t item_s1,
	output logic valid_s1,
	input logic q_ready
);
	import hrhp_pkg::*;

	hrhp_byte_t cls;

	// The stage takes a word whenever it is empty or drains into the queue.
	assign in_ch.ready = !valid_s1 || q_ready;

	// Character classes that the parser tests.
	always_comb begin
		cls.data = in_ch.data_byte;
		cls.begin_req = in_ch.begin_request;
		cls.upper = (in_ch.data_byte >= CH_UA) && (in_ch.data_byte <= CH_UZ);
		cls.lower = (in_ch.data_byte >= CH_LA) && (in_ch.data_byte <= CH_LZ);
		cls.space = in_ch.data_byte == CH_SPACE;
		cls.slash = in_ch.data_byte == CH_SLASH;
		cls.colon = in_ch.data_byte == CH_COLON;
		cls.dot = in_ch.data_byte == CH_DOT;
		cls.lf = in_ch.data_byte == CH_LF;
		cls.dash = in_ch.data_byte == CH_DASH;
		cls.one = in_ch.data_byte == CH_ONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== design/hrhp_queue.sv =====
// Short queue of classified words between the front stage and the parser.
// Depends on hrhp_pkg.
module hrhp_queue #(
	parameter int DEPTH = hrhp_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input hrhp_pkg::hrhp_byte_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output hrhp_pkg::hrhp_byte_t pop_data
);
	import hrhp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hrhp_byte_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	// The fill count moves by exactly one word per one-sided transfer.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule

// ===== design/hrhp_back.sv =====
// Back stage: the request head state machine and the result register.
// Depends on hrhp_pkg and hrhp_out_if.
module hrhp_back #(
	parameter int BUF_BYTES = hrhp_pkg::BUF_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input hrhp_pkg::hrhp_byte_t item,
	input logic item_valid,
	output logic item_ready,
	input logic [hrhp_pkg::HDR_W-1:0] header_limit,
	hrhp_out_if.source out_ch
);
	import hrhp_pkg::*;

	localparam int POS_W = $clog2(BUF_BYTES + 1);
	localparam int MAXH1 = MAX_HEADERS - 1;

	// Parser state.
	phase_t phase_q;
	logic [POS_W-1:0] pos_q;
	logic [OFS_W-1:0] mark_q;
	logic [OFS_W-1:0] key_start_q;
	logic [OFS_W-1:0] key_len_q;
	logic [MATCH_W-1:0] match_q;
	logic is_post_q;
	logic [HDR_W-1:0] count_q;

	// State as seen by this word, after an optional restart.
	phase_t phase_e;
	logic [POS_W-1:0] pos_e;
	logic [OFS_W-1:0] pos_o;
	logic [OFS_W-1:0] mark_e;
	logic [OFS_W-1:0] key_start_e;
	logic [OFS_W-1:0] key_len_e;
	logic [MATCH_W-1:0] match_e;
	logic is_post_e;
	logic [HDR_W-1:0] count_e;

	// Next state.
	phase_t phase_d;
	logic [POS_W-1:0] pos_d;
	logic [OFS_W-1:0] mark_d;
	logic [OFS_W-1:0] key_start_d;
	logic [OFS_W-1:0] key_len_d;
	logic [MATCH_W-1:0] match_d;
	logic is_post_d;
	logic [HDR_W-1:0] count_d;

	// Result of this word.
	ev_t ev;
	logic [OFS_W-1:0] s0;
	logic [OFS_W-1:0] s1;
	logic [OFS_W-1:0] v0;
	logic [OFS_W-1:0] v1;
	logic [HDR_W-1:0] idx;
	logic kept;
	logic bad;
	logic [HDR_W-1:0] limit;
	logic [MATCH_W-1:0] word_len;

	// Result register.
	logic out_valid_q;
	ev_t ev_q;
	logic post_q;
	logic [OFS_W-1:0] s0_q;
	logic [OFS_W-1:0] s1_q;
	logic [OFS_W-1:0] v0_q;
	logic [OFS_W-1:0] v1_q;
	logic [HDR_W-1:0] idx_q;
	logic kept_q;

	logic pop;

	// A word is taken whenever the result register is free or being emptied.
	assign item_ready = !out_valid_q || out_ch.ready;
	assign pop = item_valid && item_ready;

	// A new request clears the parser before its first word is looked at.
	always_comb begin
		phase_e = item.begin_req ? PH_START : phase_q;
		pos_e = item.begin_req ? '0 : pos_q;
		mark_e = item.begin_req ? '0 : mark_q;
		key_start_e = item.begin_req ? '0 : key_start_q;
		key_len_e = item.begin_req ? '0 : key_len_q;
		match_e = item.begin_req ? MATCH_NONE : match_q;
		is_post_e = item.begin_req ? 1'b0 : is_post_q;
		count_e = item.begin_req ? '0 : count_q;
		pos_o = OFS_W'(pos_e);
		word_len = is_post_e ? POST_LEN : GET_LEN;
		limit = (int'(header_limit) > MAXH1) ? HDR_W'(MAXH1) : header_limit;
	end

	// One grammar step per word.
	always_comb begin
		phase_d = phase_e;
		mark_d = mark_e;
		key_start_d = key_start_e;
		key_len_d = key_len_e;
		match_d = match_e;
		is_post_d = is_post_e;
		count_d = count_e;
		ev = EV_NONE;
		s0 = '0;
		s1 = '0;
		v0 = '0;
		v1 = '0;
		idx = '0;
		kept = 1'b0;
		bad = 1'b0;
		if (phase_e == PH_DONE) begin
			ev = EV_NONE;
		end else if (phase_e == PH_ERROR || pos_e >= POS_W'(BUF_BYTES)) begin
			bad = 1'b1;
		end else begin
			case (phase_e)
				PH_START: begin
					if (!item.upper) begin
						bad = 1'b1;
					end else begin
						if (item.data == CH_P) begin
							is_post_d = 1'b1;
							match_d = MATCH_ONE;
						end else if (item.data == CH_G) begin
							is_post_d = 1'b0;
							match_d = MATCH_ONE;
						end else begin
							match_d = MATCH_BAD;
						end
						phase_d = PH_METHOD;
					end
				end
				PH_METHOD: begin
					if (item.upper || item.space) begin
						if (match_e >= word_len) begin
							match_d = MATCH_BAD;
						end else if (item.data == method_char(is_post_e, match_e)) begin
							match_d = match_e + 1'b1;
						end else begin
							match_d = MATCH_BAD;
						end
					end else if (item.slash && match_e == word_len) begin
						mark_d = pos_o;
						phase_d = PH_URI;
					end else begin
						bad = 1'b1;
					end
				end
				PH_URI: begin
					if (item.space) begin
						ev = EV_URI;
						s0 = mark_e;
						s1 = pos_o - mark_e;
						mark_d = pos_o;
						phase_d = PH_PROTO;
					end
				end
				PH_PROTO: begin
					if (item.slash) begin
						phase_d = PH_MAJOR;
					end else if (!item.upper) begin
						bad = 1'b1;
					end
				end
				PH_MAJOR: begin
					if (item.dot) begin
						phase_d = PH_MINOR;
					end
				end
				PH_MINOR: begin
					if (item.lf) begin
						mark_d = pos_o + 1'b1;
						phase_d = PH_HSTART;
					end else if (!item.one) begin
						bad = 1'b1;
					end
				end
				PH_HSTART: begin
					if (item.upper) begin
						phase_d = PH_KEY;
					end else begin
						bad = 1'b1;
					end
				end
				PH_KEY: begin
					if (item.colon) begin
						key_start_d = mark_e;
						key_len_d = pos_o - mark_e;
						phase_d = PH_COLON;
					end else if (!(item.upper || item.lower || item.dash)) begin
						bad = 1'b1;
					end
				end
				PH_COLON: begin
					if (item.space) begin
						phase_d = PH_SPACE;
					end else begin
						bad = 1'b1;
					end
				end
				PH_SPACE: begin
					if (item.upper || item.lower) begin
						mark_d = pos_o;
						phase_d = PH_VALUE;
					end else begin
						bad = 1'b1;
					end
				end
				PH_VALUE: begin
					if (item.lf) begin
						ev = EV_HEADER;
						s0 = key_start_e;
						s1 = key_len_e;
						v0 = mark_e;
						v1 = pos_o - mark_e;
						if (count_e < limit) begin
							kept = 1'b1;
							idx = count_e;
							count_d = count_e + 1'b1;
						end
						phase_d = PH_VDONE;
					end
				end
				PH_VDONE: begin
					if (item.upper) begin
						mark_d = pos_o;
						phase_d = PH_KEY;
					end else if (item.lf) begin
						ev = EV_DONE;
						phase_d = PH_DONE;
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					bad = 1'b1;
				end
			endcase
		end
		if (bad) begin
			phase_d = PH_ERROR;
			ev = EV_ERROR;
			s0 = '0;
			s1 = '0;
			v0 = '0;
			v1 = '0;
			idx = '0;
			kept = 1'b0;
		end
		// The position stops counting once it reaches the buffer size.
		pos_d = (pos_e < POS_W'(BUF_BYTES)) ? pos_e + 1'b1 : pos_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pos_q <= '0;
			mark_q <= '0;
			key_start_q <= '0;
			key_len_q <= '0;
			match_q <= MATCH_NONE;
			is_post_q <= 1'b0;
			count_q <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			mark_q <= mark_d;
			key_start_q <= key_start_d;
			key_len_q <= key_len_d;
			match_q <= match_d;
			is_post_q <= is_post_d;
			count_q <= count_d;
		end
	end

	// The result register holds one word of results until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q <= ev;
			post_q <= is_post_d;
			s0_q <= s0;
			s1_q <= s1;
			v0_q <= v0;
			v1_q <= v1;
			idx_q <= idx;
			kept_q <= kept;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.event_res = ev_q;
	assign out_ch.method_post = post_q;
	assign out_ch.span_start = s0_q;
	assign out_ch.span_len = s1_q;
	assign out_ch.value_start = v0_q;
	assign out_ch.value_len = v1_q;
	assign out_ch.header_index = idx_q;
	assign out_ch.header_kept = kept_q;

`ifndef SYNTHESIS
	// Every word taken leaves a result waiting in the next cycle.
	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("word taken without a result");

	// The error phase holds until a new request begins.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && phase_q == PH_ERROR && !item.begin_req) |=> (ev_q == EV_ERROR))
		else $error("error phase left without a new request");

	// An error result carries no spans.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ev_q == EV_ERROR) |->
		(s0_q == '0 && s1_q == '0 && v0_q == '0 && v1_q == '0 && !kept_q))
		else $error("error result with span data");
`endif

endmodule

// ===== design/http_request_head_parser_top.sv =====
// Top level of the HTTP request head parser: channels, configuration port and
// the front, queue and back parts. Depends on hrhp_pkg, hrhp_if and the parts.
//
// The block takes one request word per cycle unless stalled and returns one parse
// event per word, in order. The rate is set by the parser's state machine; the
// front classifier, the two-entry queue and the result register let input and
// output stall independently. begin_request restarts parsing at that word;
// header_limit is written through the APB port at byte address 0 while idle, a
// rule for the user that the block does not enforce.
module http_request_head_parser_top #(
	parameter int BUF_BYTES = hrhp_pkg::BUF_BYTES_DEF,
	parameter int QUEUE_DEPTH = hrhp_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	hrhp_in_if.sink in_ch,
	hrhp_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [hrhp_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [hrhp_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [hrhp_pkg::CFG_DATA_W-1:0] prdata,
	output logic pready
);
	import hrhp_pkg::*;

	logic [HDR_W-1:0] header_limit_q;
	logic [CFG_ADDR_W-3:0] reg_index;
	hrhp_byte_t front_item_s1;
	logic front_valid_s1;
	logic q_push_ready;
	hrhp_byte_t q_item;
	logic q_valid;
	logic back_ready;

	// Configuration register access.
	assign pready = 1'b1;
	assign reg_index = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_limit_q <= HEADER_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_index == REG_HEADER_LIMIT) begin
			header_limit_q <= pwdata[HDR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_index == REG_HEADER_LIMIT) begin
			prdata = CFG_DATA_W'(header_limit_q);
		end
	end

	hrhp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.item_s1(front_item_s1),
		.valid_s1(front_valid_s1),
		.q_ready(q_push_ready)
	);

	hrhp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(front_valid_s1),
		.push_ready(q_push_ready),
		.push_data(front_item_s1),
		.pop_valid(q_valid),
		.pop_ready(back_ready),
		.pop_data(q_item)
	);

	hrhp_back #(
		.BUF_BYTES(BUF_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(q_item),
		.item_valid(q_valid),
		.item_ready(back_ready),
		.header_limit(header_limit_q),
		.out_ch(out_ch)
	);

endmodule

// ===== bench/hrhp_event_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard of the HTTP request head parser bench: a bit-true predictor of the
// parse events and the queue of events still due. Depends on hrhp_pkg.
package hrhp_bench_pkg;
	import hrhp_pkg::*;

	localparam int BUF_LIMIT = BUF_BYTES_DEF;
	localparam logic [31:0] GET_WORD = "GET ";
	localparam logic [39:0] POST_WORD = "POST ";

	// One parse event as it leaves the block.
	typedef struct packed {
		ev_t event_res;
		logic method_post;
		logic [OFS_W-1:0] span_start;
		logic [OFS_W-1:0] span_len;
		logic [OFS_W-1:0] value_start;
		logic [OFS_W-1:0] value_len;
		logic [HDR_W-1:0] header_index;
		logic header_kept;
	} parse_event_t;

	class parse_event_scoreboard;
		phase_t phase;
		logic [OFS_W:0] position;
		logic [OFS_W:0] mark;
		logic [OFS_W:0] key_start;
		logic [OFS_W:0] key_len;
		logic [MATCH_W-1:0] method_progress;
		logic is_post;
		logic [HDR_W-1:0] header_count;
		logic [HDR_W-1:0] header_limit;
		parse_event_t expected_events[$];
		int unsigned failures;

		function new();
			restart();
			header_limit = HEADER_LIMIT_RESET;
			failures = 0;
		endfunction

		// A new request clears the parser but keeps the register.
		function void restart();
			phase = PH_START;
			position = '0;
			mark = '0;
			key_start = '0;
			key_len = '0;
			method_progress = MATCH_NONE;
			is_post = 1'b0;
			header_count = '0;
		endfunction

		function void set_limit(logic [HDR_W-1:0] limit);
			header_limit = limit;
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		function bit is_upper(logic [DATA_W-1:0] c);
			return c >= CH_UA && c <= CH_UZ;
		endfunction

		function bit is_lower(logic [DATA_W-1:0] c);
			return c >= CH_LA && c <= CH_LZ;
		endfunction

		function logic [MATCH_W-1:0] word_len();
			return is_post ? POST_LEN : GET_LEN;
		endfunction

		function logic [DATA_W-1:0] method_letter(logic [MATCH_W-1:0] n);
			return is_post ? POST_WORD[39 - 8*n -: 8] : GET_WORD[31 - 8*n -: 8];
		endfunction

		// Method letters must spell the chosen word exactly; anything longer is a mismatch.
		function void advance_method(logic [DATA_W-1:0] c);
			if (method_progress >= word_len())
				method_progress = MATCH_BAD;
			else if (c == method_letter(method_progress))
				method_progress = method_progress + 1'b1;
			else
				method_progress = MATCH_BAD;
		endfunction

		// Works out the event of one accepted word and queues it.
		function void note_word(logic [DATA_W-1:0] c, logic begin_req);
			parse_event_t r;
			logic fault;
			logic [HDR_W-1:0] cap;
			r = '0;
			fault = 1'b0;
			if (begin_req)
				restart();
			if (phase == PH_DONE) begin
				r.event_res = EV_NONE;
			end else if (phase == PH_ERROR || position >= BUF_LIMIT) begin
				fault = 1'b1;
			end else begin
				case (phase)
					PH_START: begin
						if (!is_upper(c)) begin
							fault = 1'b1;
						end else begin
							if (c == CH_P) begin
								is_post = 1'b1;
								method_progress = MATCH_ONE;
							end else if (c == CH_G) begin
								is_post = 1'b0;
								method_progress = MATCH_ONE;
							end else begin
								method_progress = MATCH_BAD;
							end
							phase = PH_METHOD;
						end
					end
					PH_METHOD: begin
						if (is_upper(c) || c == CH_SPACE) begin
							advance_method(c);
						end else if (c == CH_SLASH && method_progress == word_len()) begin
							mark = position;
							phase = PH_URI;
						end else begin
							fault = 1'b1;
						end
					end
					PH_URI: begin
						if (c == CH_SPACE) begin
							r.event_res = EV_URI;
							r.span_start = mark[OFS_W-1:0];
							r.span_len = OFS_W'(position - mark);
							mark = position;
							phase = PH_PROTO;
						end
					end
					PH_PROTO: begin
						if (c == CH_SLASH)
							phase = PH_MAJOR;
						else if (!is_upper(c))
							fault = 1'b1;
					end
					PH_MAJOR: begin
						if (c == CH_DOT)
							phase = PH_MINOR;
					end
					PH_MINOR: begin
						if (c == CH_LF) begin
							mark = position + 1'b1;
							phase = PH_HSTART;
						end else if (c != CH_ONE) begin
							fault = 1'b1;
						end
					end
					PH_HSTART: begin
						if (is_upper(c))
							phase = PH_KEY;
						else
							fault = 1'b1;
					end
					PH_KEY: begin
						if (c == CH_COLON) begin
							key_start = mark;
							key_len = position - mark;
							phase = PH_COLON;
						end else if (!(is_upper(c) || is_lower(c) || c == CH_DASH)) begin
							fault = 1'b1;
						end
					end
					PH_COLON: begin
						if (c == CH_SPACE)
							phase = PH_SPACE;
						else
							fault = 1'b1;
					end
					PH_SPACE: begin
						if (is_upper(c) || is_lower(c)) begin
							mark = position;
							phase = PH_VALUE;
						end else begin
							fault = 1'b1;
						end
					end
					PH_VALUE: begin
						if (c == CH_LF) begin
							r.event_res = EV_HEADER;
							r.span_start = key_start[OFS_W-1:0];
							r.span_len = key_len[OFS_W-1:0];
							r.value_start = mark[OFS_W-1:0];
							r.value_len = OFS_W'(position - mark);
							// The register can never lift the limit past the hard maximum.
							cap = (header_limit > MAX_HEADERS - 1) ? HDR_W'(MAX_HEADERS - 1)
								: header_limit;
							if (header_count < cap) begin
								r.header_kept = 1'b1;
								r.header_index = header_count;
								header_count = header_count + 1'b1;
							end
							phase = PH_VDONE;
						end
					end
					PH_VDONE: begin
						if (is_upper(c)) begin
							mark = position;
							phase = PH_KEY;
						end else if (c == CH_LF) begin
							r.event_res = EV_DONE;
							phase = PH_DONE;
						end else begin
							fault = 1'b1;
						end
					end
					default: fault = 1'b1;
				endcase
			end
			// Errors clear every span field and stick until the next request.
			if (fault) begin
				phase = PH_ERROR;
				r = '0;
				r.event_res = EV_ERROR;
			end
			r.method_post = is_post;
			if (position < BUF_LIMIT)
				position = position + 1'b1;
			expected_events.push_back(r);
		endfunction

		function void compare(string name, logic [OFS_W-1:0] want, logic [OFS_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		// Compares one delivered event with the oldest one due.
		function void check_event(parse_event_t got);
			parse_event_t want;
			if (expected_events.size() == 0) begin
				$error("event_res: expected no event, got %0d", got.event_res);
				failures++;
				return;
			end
			want = expected_events.pop_front();
			compare("event_res", want.event_res, got.event_res);
			compare("method_post", want.method_post, got.method_post);
			compare("span_start", want.span_start, got.span_start);
			compare("span_len", want.span_len, got.span_len);
			compare("value_start", want.value_start, got.value_start);
			compare("value_len", want.value_len, got.value_len);
			compare("header_index", want.header_index, got.header_index);
			compare("header_kept", want.header_kept, got.header_kept);
		endfunction
	endclass

endpackage

// ===== bench/tb_http_request_head_parser_top.sv =====
`timescale 1ns / 1ps
// Bench top of the HTTP request head parser: drives request words and the APB
// register, checks every parse event. Depends on hrhp_pkg, hrhp_if, hrhp_bench_pkg.
module tb_http_request_head_parser_top;
	import hrhp_pkg::*;
	import hrhp_bench_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 80;
	localparam int WORDS_PER_PHASE = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	hrhp_in_if in_ch();
	hrhp_out_if out_ch();

	http_request_head_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	parse_event_scoreboard sb;
	logic [DATA_W-1:0] req_bytes[$];
	logic req_begin[$];
	bit sender_calm = 1'b0;
	bit long_hold_req = 1'b0;
	int unsigned cycle_count = 0;

	always #1 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Every event taken from the block is checked against the oldest one due.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_event(parse_event_t'({out_ch.event_res, out_ch.method_post,
				out_ch.span_start, out_ch.span_len, out_ch.value_start, out_ch.value_len,
				out_ch.header_index, out_ch.header_kept}));
	end

	// Event receiver: random stalls, calm stretches, and one long hold on request.
	initial begin : event_sink
		int gap;
		int served;
		bit calm;
		served = 0;
		calm = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				gap = LONG_HOLD;
			end else begin
				gap = calm ? 0 : $urandom_range(0, 4);
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			served++;
			if (served % 32 == 0)
				calm = ($urandom_range(0, 3) == 0);
		end
	end

	function automatic logic [DATA_W-1:0] rand_upper();
		return CH_UA + DATA_W'($urandom_range(0, 25));
	endfunction

	function automatic logic [DATA_W-1:0] rand_letter();
		return $urandom_range(0, 1) ? rand_upper() : CH_LA + DATA_W'($urandom_range(0, 25));
	endfunction

	function automatic logic [DATA_W-1:0] any_but(logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] v;
		do v = DATA_W'($urandom_range(0, 255)); while (v == x);
		return v;
	endfunction

	task automatic put(logic [DATA_W-1:0] b);
		req_bytes.push_back(b);
		req_begin.push_back(1'b0);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	// Offers one word after a random gap, none when calm, and waits for it to be taken.
	task automatic send_word(logic [DATA_W-1:0] b, logic first);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.begin_request <= first;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_word(b, first);
	endtask

	task automatic send_request();
		foreach (req_bytes[i])
			send_word(req_bytes[i], req_begin[i]);
		req_bytes.delete();
		req_begin.delete();
	endtask

	// Stops offering words until every event has arrived and the block is quiet.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [HDR_W-1:0] limit);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_HEADER_LIMIT, 2'b00};
		pwdata <= {(CFG_DATA_W - HDR_W)'($urandom), limit};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_limit(limit);
	endtask

	// Builds a request, well-formed unless its method is garbled; a terse one has the
	// shortest fields everywhere but the URI, so byte positions can be placed exactly.
	task automatic build_request(int uri_len, int n_hdr, bit terse);
		int n;
		req_bytes.delete();
		req_begin.delete();
		if (terse) begin
			put_text("GET ");
		end else begin
			case ($urandom_range(0, 7))
				0: begin
					// Method that is not quite GET or POST.
					n = $urandom_range(1, 6);
					put(($urandom_range(0, 2) == 0) ? rand_upper()
						: ($urandom_range(0, 1) ? CH_G : CH_P));
					repeat (n - 1) put(($urandom_range(0, 3) == 0) ? CH_SPACE : rand_upper());
				end
				1, 2, 3: put_text("GET ");
				default: put_text("POST ");
			endcase
		end
		put(CH_SLASH);
		repeat (uri_len - 1) put(any_but(CH_SPACE));
		put(CH_SPACE);
		if (!terse)
			repeat ($urandom_range(0, 5)) put(rand_upper());
		put(CH_SLASH);
		if (!terse)
			repeat ($urandom_range(0, 3)) put(any_but(CH_DOT));
		put(CH_DOT);
		if (!terse)
			repeat ($urandom_range(0, 3)) put(CH_ONE);
		put(CH_LF);
		repeat (n_hdr) begin
			put(rand_upper());
			if (!terse)
				repeat ($urandom_range(0, 7)) begin
					case ($urandom_range(0, 2))
						0: put(rand_upper());
						1: put(CH_LA + DATA_W'($urandom_range(0, 25)));
						default: put(CH_DASH);
					endcase
				end
			put(CH_COLON);
			put(CH_SPACE);
			put(rand_letter());
			if (!terse)
				repeat ($urandom_range(0, 11)) put(any_but(CH_LF));
			put(CH_LF);
		end
		put(CH_LF);
		req_begin[0] = 1'b1;
	endtask

	// Some clean requests; the rest broken, restarted, cut short, unflagged or noise.
	task automatic send_random_request(output int words);
		int cut;
		int n;
		build_request($urandom_range(1, 12),
			($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6), 1'b0);
		cut = $urandom_range(0, req_bytes.size() - 1);
		case ($urandom_range(0, 11))
			0, 1, 2: req_bytes[cut] = DATA_W'($urandom_range(0, 255));
			3: req_begin[cut] = 1'b1;
			4: begin
				req_bytes = req_bytes[0:cut];
				req_begin = req_begin[0:cut];
			end
			5: req_begin[0] = 1'b0;
			6: begin
				req_bytes.delete();
				req_begin.delete();
				n = $urandom_range(1, 6);
				repeat (n) begin
					req_bytes.push_back(DATA_W'($urandom_range(0, 255)));
					req_begin.push_back(1'($urandom_range(0, 1)));
				end
			end
			default: ;
		endcase
		words = req_bytes.size();
		// Stray words may follow; once a request is done they yield EV_NONE.
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) put(DATA_W'($urandom_range(0, 255)));
		sender_calm = ($urandom_range(0, 3) == 0);
		send_request();
	endtask

	initial begin : stimulus
		int sent;
		int words;
		logic [HDR_W-1:0] limit;
		sb = new();
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.begin_request <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a bad first word with no begin flag, then a sticky error.
		put(8'h00);
		put(8'hFF);
		send_request();
		// Shortest one-header request, a word after it is done, then one with no headers.
		put_text("GET / /.\nA: a\n\n");
		req_begin[0] = 1'b1;
		send_request();
		put(8'h7F);
		send_request();
		put_text("POST / /.\n\n");
		req_begin[0] = 1'b1;
		send_request();
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: limit = '0;
				1: limit = '1;
				2: limit = HDR_W'(1);
				3: limit = HDR_W'(2);
				default: limit = HDR_W'($urandom_range(0, 63));
			endcase
			cfg_write(limit);
			if (p == 1) begin
				// Receiver holds off while a request with more headers than fit streams in.
				build_request(3, 66, 1'b1);
				sender_calm = 1'b1;
				long_hold_req = 1'b1;
				send_request();
			end
			if (p == 5) begin
				// Final line feed lands on the last buffer position.
				build_request(4082, 1, 1'b1);
				send_request();
				// The URI runs past the end of the buffer.
				build_request(4095, 1, 1'b1);
				send_request();
			end
			sent = 0;
			while (sent < WORDS_PER_PHASE) begin
				send_random_request(words);
				sent += words;
			end
			wait_idle();
		end

		if (sb.failures == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hrhp_pkg.sv
design/hrhp_if.sv
design/hrhp_front.sv
design/hrhp_queue.sv
design/hrhp_back.sv
design/http_request_head_parser_top.sv
bench/hrhp_event_scoreboard.sv
bench/tb_http_request_head_parser_top.sv
